// ===== src/wbdc_pkg.sv =====
// ----------------------------------------------------------------------------
// wbdc_pkg
// Shared types, codes and sizes for the waste bin door controller.
// ----------------------------------------------------------------------------
package wbdc_pkg;

   localparam int TIMER_BITS    = 16;
   localparam int LEVEL_BITS    = 10;
   localparam int CFG_TIME_BITS = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int ELAPSED_BITS  = 8;
   localparam int CMP_BITS      = (TIMER_BITS > CFG_TIME_BITS) ? TIMER_BITS : CFG_TIME_BITS;

   // percentage: 100 * level difference, then a 7-bit restoring division
   localparam int PCT_BITS      = 7;
   localparam int PCT_PROD_BITS = LEVEL_BITS + PCT_BITS;
   localparam int DIV_STEPS     = PCT_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
   localparam int PCT_FULL      = 100;
   localparam int OPEN_FULL_MIN_MS = 1000;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_OPEN_TIME     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLOSE_TIME    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EMPTYING_TIME = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EMPTY_LEVEL   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_LEVEL    = 3'd4;

   localparam logic [CFG_TIME_BITS-1:0] RST_OPEN_TIME     = 16'd5000;
   localparam logic [CFG_TIME_BITS-1:0] RST_CLOSE_TIME    = 16'd2000;
   localparam logic [CFG_TIME_BITS-1:0] RST_EMPTYING_TIME = 16'd3000;
   localparam logic [LEVEL_BITS-1:0]    RST_EMPTY_LEVEL   = LEVEL_BITS'(200);
   localparam logic [LEVEL_BITS-1:0]    RST_FULL_LEVEL    = LEVEL_BITS'(20);

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_OPEN     = 3'd1,
      MODE_SLEEP    = 3'd2,
      MODE_CLOSE    = 3'd3,
      MODE_EMPTYING = 3'd4,
      MODE_FULL     = 3'd5
   } mode_type;

   localparam logic [1:0] DOOR_NONE    = 2'd0;
   localparam logic [1:0] DOOR_OPEN    = 2'd1;
   localparam logic [1:0] DOOR_CLOSE   = 2'd2;
   localparam logic [1:0] DOOR_REVERSE = 2'd3;

   localparam logic [2:0] MSG_NONE       = 3'd0;
   localparam logic [2:0] MSG_PRESS_OPEN = 3'd1;
   localparam logic [2:0] MSG_OPENED     = 3'd2;
   localparam logic [2:0] MSG_RECEIVED   = 3'd3;
   localparam logic [2:0] MSG_EMPTYING   = 3'd4;
   localparam logic [2:0] MSG_FULL       = 3'd5;
   localparam logic [2:0] MSG_BLANK      = 3'd6;

   typedef struct packed {
      logic load_in;
      logic eval;
      logic div_step;
      logic write_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== src/wbdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wbdc_ctrl
// Sequencer: takes a word, runs the mode step, the division, then the result.
// ----------------------------------------------------------------------------
module wbdc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  wbdc_pkg::ctrl_status_type status,
   output wbdc_pkg::ctrl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [wbdc_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic div_last;

   assign div_last = (cnt_ff == wbdc_pkg::DIV_CNT_BITS'(wbdc_pkg::DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign cmd.load_in   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.eval      = (state_ff == ST_EVAL);
   assign cmd.div_step  = (state_ff == ST_DIV);
   assign cmd.write_out = (state_ff == ST_DONE) && status.out_free;

endmodule

// ===== src/wbdc_dpath.sv =====
// ----------------------------------------------------------------------------
// wbdc_dpath
// Config registers, mode state, tick evaluation, fill divider, result word.
// ----------------------------------------------------------------------------
module wbdc_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wbdc_pkg::ctrl_cmd_type                cmd,
   output wbdc_pkg::ctrl_status_type             status,
   input  logic [wbdc_pkg::ELAPSED_BITS-1:0]     req_elapsed_ms,
   input  logic                                  req_user_present,
   input  logic                                  req_open_button,
   input  logic                                  req_close_button,
   input  logic [wbdc_pkg::LEVEL_BITS-1:0]       req_fill_distance,
   input  logic                                  req_empty_request,
   input  logic                                  req_problem_active,
   input  logic                                  csr_write,
   input  logic [wbdc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [wbdc_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_mode_now,
   output logic [1:0]                            rsp_door_command,
   output logic [2:0]                            rsp_message_code,
   output logic                                  rsp_green_led,
   output logic                                  rsp_red_led,
   output logic                                  rsp_percent_valid,
   output logic [wbdc_pkg::PCT_BITS-1:0]         rsp_fill_percent
);

   localparam int TB = wbdc_pkg::TIMER_BITS;
   localparam int LB = wbdc_pkg::LEVEL_BITS;
   localparam int PB = wbdc_pkg::PCT_PROD_BITS;
   localparam int QB = wbdc_pkg::PCT_BITS;
   localparam int CB = wbdc_pkg::CMP_BITS;

   // configuration
   logic [wbdc_pkg::CFG_TIME_BITS-1:0] open_time_ff, close_time_ff, empt_time_ff;
   logic [LB-1:0] empty_lvl_ff, full_lvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_time_ff <= wbdc_pkg::RST_OPEN_TIME;
         close_time_ff <= wbdc_pkg::RST_CLOSE_TIME;
         empt_time_ff <= wbdc_pkg::RST_EMPTYING_TIME;
         empty_lvl_ff <= wbdc_pkg::RST_EMPTY_LEVEL;
         full_lvl_ff  <= wbdc_pkg::RST_FULL_LEVEL;
      end else if (csr_write) begin
         unique case (csr_index)
            wbdc_pkg::CSR_OPEN_TIME:     open_time_ff  <= csr_data;
            wbdc_pkg::CSR_CLOSE_TIME:    close_time_ff <= csr_data;
            wbdc_pkg::CSR_EMPTYING_TIME: empt_time_ff  <= csr_data;
            wbdc_pkg::CSR_EMPTY_LEVEL:   empty_lvl_ff  <= csr_data[LB-1:0];
            wbdc_pkg::CSR_FULL_LEVEL:    full_lvl_ff   <= csr_data[LB-1:0];
            default: ;
         endcase
      end
   end

   // input word capture
   logic [wbdc_pkg::ELAPSED_BITS-1:0] elapsed_ff;
   logic user_ff, open_btn_ff, close_btn_ff, empty_req_ff, problem_ff;
   logic [LB-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         elapsed_ff   <= req_elapsed_ms;
         user_ff      <= req_user_present;
         open_btn_ff  <= req_open_button;
         close_btn_ff <= req_close_button;
         dist_ff      <= req_fill_distance;
         empty_req_ff <= req_empty_request;
         problem_ff   <= req_problem_active;
      end
   end

   // controller state
   wbdc_pkg::mode_type mode_ff, mode_in;
   logic entry_ff, entry_in;
   logic [TB-1:0] timer_ff, timer_in;
   logic green_ff, green_in, red_ff, red_in, prob_ff, prob_in;
   logic [1:0] door_in;
   logic [2:0] msg_in;
   logic pvalid_in;

   logic [TB:0]   tsum;
   logic [TB-1:0] tsat;

   assign tsum = {1'b0, timer_ff} + (TB + 1)'(elapsed_ff);
   assign tsat = tsum[TB] ? {TB{1'b1}} : tsum[TB-1:0];

   always_comb begin
      mode_in   = mode_ff;
      entry_in  = entry_ff;
      timer_in  = timer_ff;
      green_in  = green_ff;
      red_in    = red_ff;
      prob_in   = prob_ff;
      door_in   = wbdc_pkg::DOOR_NONE;
      msg_in    = wbdc_pkg::MSG_NONE;
      pvalid_in = 1'b0;
      if (problem_ff) begin
         prob_in = 1'b1;
      end else begin
         entry_in = entry_ff | prob_ff;
         prob_in  = 1'b0;
         if ((mode_ff == wbdc_pkg::MODE_OPEN || mode_ff == wbdc_pkg::MODE_CLOSE ||
              mode_ff == wbdc_pkg::MODE_EMPTYING) && !entry_in) begin
            timer_in = tsat;
         end
         unique case (mode_ff)
            wbdc_pkg::MODE_OPEN: begin
               pvalid_in = 1'b1;
               if (entry_in) begin
                  msg_in   = wbdc_pkg::MSG_OPENED;
                  door_in  = wbdc_pkg::DOOR_OPEN;
                  timer_in = '0;
                  entry_in = 1'b0;
               end
               if (CB'(timer_in) > CB'(open_time_ff) || close_btn_ff) begin
                  mode_in  = wbdc_pkg::MODE_CLOSE;
                  entry_in = 1'b1;
               end
               // full wins over close
               if (dist_ff <= full_lvl_ff &&
                   CB'(timer_in) > CB'(wbdc_pkg::OPEN_FULL_MIN_MS)) begin
                  mode_in  = wbdc_pkg::MODE_FULL;
                  entry_in = 1'b1;
               end
            end
            wbdc_pkg::MODE_SLEEP: begin
               if (entry_in) begin
                  msg_in   = wbdc_pkg::MSG_BLANK;
                  entry_in = 1'b0;
               end
               if (user_ff) begin
                  mode_in  = wbdc_pkg::MODE_IDLE;
                  entry_in = 1'b1;
               end
            end
            wbdc_pkg::MODE_CLOSE: begin
               if (entry_in) begin
                  msg_in   = wbdc_pkg::MSG_RECEIVED;
                  door_in  = wbdc_pkg::DOOR_CLOSE;
                  timer_in = '0;
                  entry_in = 1'b0;
               end
               if (CB'(timer_in) > CB'(close_time_ff)) begin
                  mode_in  = wbdc_pkg::MODE_IDLE;
                  entry_in = 1'b1;
               end
            end
            wbdc_pkg::MODE_EMPTYING: begin
               pvalid_in = 1'b1;
               if (entry_in) begin
                  msg_in   = wbdc_pkg::MSG_EMPTYING;
                  door_in  = wbdc_pkg::DOOR_REVERSE;
                  timer_in = '0;
                  entry_in = 1'b0;
               end
               if (CB'(timer_in) > CB'(empt_time_ff)) begin
                  door_in  = wbdc_pkg::DOOR_CLOSE;
                  mode_in  = wbdc_pkg::MODE_IDLE;
                  entry_in = 1'b1;
               end
            end
            wbdc_pkg::MODE_FULL: begin
               if (entry_in) begin
                  msg_in   = wbdc_pkg::MSG_FULL;
                  door_in  = wbdc_pkg::DOOR_CLOSE;
                  green_in = 1'b0;
                  red_in   = 1'b1;
                  entry_in = 1'b0;
               end
               if (empty_req_ff) begin
                  mode_in  = wbdc_pkg::MODE_EMPTYING;
                  entry_in = 1'b1;
               end
            end
            default: begin
               mode_in = wbdc_pkg::MODE_IDLE;
               if (user_ff) begin
                  if (entry_in) begin
                     green_in = 1'b1;
                     red_in   = 1'b0;
                     msg_in   = wbdc_pkg::MSG_PRESS_OPEN;
                     entry_in = 1'b0;
                  end
                  if (open_btn_ff) begin
                     mode_in  = wbdc_pkg::MODE_OPEN;
                     entry_in = 1'b1;
                  end
               end else begin
                  mode_in  = wbdc_pkg::MODE_SLEEP;
                  entry_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= wbdc_pkg::MODE_IDLE;
         entry_ff <= 1'b1;
         timer_ff <= '0;
         green_ff <= 1'b0;
         red_ff   <= 1'b0;
         prob_ff  <= 1'b0;
      end else if (cmd.eval) begin
         mode_ff  <= mode_in;
         entry_ff <= entry_in;
         timer_ff <= timer_in;
         green_ff <= green_in;
         red_ff   <= red_in;
         prob_ff  <= prob_in;
      end
   end

   // tick result held while the division runs
   logic [2:0] res_mode_ff, res_msg_ff;
   logic [1:0] res_door_ff;
   logic res_pvalid_ff, pct_div_ff;
   logic [QB-1:0] pct_fixed_ff;

   // fill percentage: fixed ends, otherwise 100*(E-d)/(E-F) by restoring division
   logic pct_zero, pct_hundred;
   logic [LB-1:0] num_diff, den_diff;
   logic [PB-1:0] num_init, den_init;
   logic [PB-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QB-1:0] quo_ff, quo_in;

   assign pct_zero    = (dist_ff >= empty_lvl_ff);
   assign pct_hundred = (dist_ff <= full_lvl_ff);
   assign num_diff    = empty_lvl_ff - dist_ff;
   assign den_diff    = empty_lvl_ff - full_lvl_ff;
   assign num_init    = PB'(num_diff) * PB'(wbdc_pkg::PCT_FULL);
   assign den_init    = PB'(den_diff) << (wbdc_pkg::DIV_STEPS - 1);

   always_comb begin
      rem_in = rem_ff;
      quo_in = {quo_ff[QB-2:0], 1'b0};
      dsh_in = dsh_ff >> 1;
      if (rem_ff >= dsh_ff) begin
         rem_in = rem_ff - dsh_ff;
         quo_in = {quo_ff[QB-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         res_mode_ff   <= 3'(mode_in);
         res_door_ff   <= door_in;
         res_msg_ff    <= msg_in;
         res_pvalid_ff <= pvalid_in;
         pct_div_ff    <= pvalid_in && !pct_zero && !pct_hundred;
         pct_fixed_ff  <= (pvalid_in && !pct_zero) ? QB'(wbdc_pkg::PCT_FULL) : '0;
         rem_ff        <= num_init;
         dsh_ff        <= den_init;
         quo_ff        <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dsh_ff <= dsh_in;
         quo_ff <= quo_in;
      end
   end

   logic [QB-1:0] pct_final;
   assign pct_final = !pct_div_ff ? pct_fixed_ff :
                      (quo_ff > QB'(wbdc_pkg::PCT_FULL)) ? QB'(wbdc_pkg::PCT_FULL) : quo_ff;

   // output word register
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] out_mode_ff, out_msg_ff;
   logic [1:0] out_door_ff;
   logic out_green_ff, out_red_ff, out_pvalid_ff;
   logic [QB-1:0] out_pct_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.write_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_out) begin
         out_mode_ff   <= res_mode_ff;
         out_door_ff   <= res_door_ff;
         out_msg_ff    <= res_msg_ff;
         out_green_ff  <= green_ff;
         out_red_ff    <= red_ff;
         out_pvalid_ff <= res_pvalid_ff;
         out_pct_ff    <= pct_final;
      end
   end

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode_now      = out_mode_ff;
   assign rsp_door_command  = out_door_ff;
   assign rsp_message_code  = out_msg_ff;
   assign rsp_green_led     = out_green_ff;
   assign rsp_red_led       = out_red_ff;
   assign rsp_percent_valid = out_pvalid_ff;
   assign rsp_fill_percent  = out_pct_ff;

endmodule

// ===== src/waste_bin_door_controller_core.sv =====
// Waste bin door controller: one input word is one task tick; each tick gives
// exactly one result word with the mode after the tick, door and message codes,
// LED levels and, in the open and emptying modes, the fill percentage. A result
// word is valid once its tick has gone through the mode step, the restoring
// fill-percentage divider and the result write, and the next tick is taken in
// the cycle after the result write; a word is not taken before the result of
// the last one is written. A new word is taken while the previous result still
// waits in the output register; a finished result that finds the output
// register still stalled holds the sequencer, and the input stalls, until it
// can be written. Configuration registers are written through the csr port
// and take effect on the next tick.
// ----------------------------------------------------------------------------
// waste_bin_door_controller_core
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
module waste_bin_door_controller_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [wbdc_pkg::ELAPSED_BITS-1:0]     req_elapsed_ms,
   input  logic                                  req_user_present,
   input  logic                                  req_open_button,
   input  logic                                  req_close_button,
   input  logic [wbdc_pkg::LEVEL_BITS-1:0]       req_fill_distance,
   input  logic                                  req_empty_request,
   input  logic                                  req_problem_active,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_mode_now,
   output logic [1:0]                            rsp_door_command,
   output logic [2:0]                            rsp_message_code,
   output logic                                  rsp_green_led,
   output logic                                  rsp_red_led,
   output logic                                  rsp_percent_valid,
   output logic [wbdc_pkg::PCT_BITS-1:0]         rsp_fill_percent,
   input  logic                                  csr_write,
   input  logic [wbdc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [wbdc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   wbdc_pkg::ctrl_cmd_type    cmd;
   wbdc_pkg::ctrl_status_type status;

   wbdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wbdc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_user_present   (req_user_present),
      .req_open_button    (req_open_button),
      .req_close_button   (req_close_button),
      .req_fill_distance  (req_fill_distance),
      .req_empty_request  (req_empty_request),
      .req_problem_active (req_problem_active),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mode_now       (rsp_mode_now),
      .rsp_door_command   (rsp_door_command),
      .rsp_message_code   (rsp_message_code),
      .rsp_green_led      (rsp_green_led),
      .rsp_red_led        (rsp_red_led),
      .rsp_percent_valid  (rsp_percent_valid),
      .rsp_fill_percent   (rsp_fill_percent)
   );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the waste bin door controller core. Tick words go
// in through a queue-fed driver. A local copy of the mode logic predicts each
// result word, and the monitor compares every returned word field by field.
// The run covers directed ticks, random ticks under several register
// settings, a timer saturation run and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [wbdc_pkg::ELAPSED_BITS-1:0] elapsed;
      logic                              user;
      logic                              open_btn;
      logic                              close_btn;
      logic [wbdc_pkg::LEVEL_BITS-1:0]   fill_dist;
      logic                              empty_req;
      logic                              problem;
   } tick_word_type;

   typedef struct packed {
      logic [2:0]                    mode;
      logic [1:0]                    door;
      logic [2:0]                    msg;
      logic                          green;
      logic                          red;
      logic                          pct_valid;
      logic [wbdc_pkg::PCT_BITS-1:0] pct;
   } status_word_type;

   logic                              clock;
   logic                              reset              = 1'b1;
   logic                              req_valid          = 1'b0;
   logic                              req_stall;
   logic [wbdc_pkg::ELAPSED_BITS-1:0] req_elapsed_ms     = '0;
   logic                              req_user_present   = 1'b0;
   logic                              req_open_button    = 1'b0;
   logic                              req_close_button   = 1'b0;
   logic [wbdc_pkg::LEVEL_BITS-1:0]   req_fill_distance  = '0;
   logic                              req_empty_request  = 1'b0;
   logic                              req_problem_active = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall          = 1'b0;
   logic [2:0]                        rsp_mode_now;
   logic [1:0]                        rsp_door_command;
   logic [2:0]                        rsp_message_code;
   logic                              rsp_green_led;
   logic                              rsp_red_led;
   logic                              rsp_percent_valid;
   logic [wbdc_pkg::PCT_BITS-1:0]     rsp_fill_percent;
   logic                              csr_write          = 1'b0;
   logic [wbdc_pkg::CSR_IDX_BITS-1:0] csr_index          = '0;
   logic [wbdc_pkg::CSR_DATA_BITS-1:0] csr_data          = '0;

   // predicted controller state and register copies
   wbdc_pkg::mode_type                 cur_mode     = wbdc_pkg::MODE_IDLE;
   logic                               entry_due    = 1'b1;
   logic [wbdc_pkg::TIMER_BITS-1:0]    dwell_ms     = '0;
   logic                               green_on     = 1'b0;
   logic                               red_on       = 1'b0;
   logic                               problem_seen = 1'b0;
   logic [wbdc_pkg::CFG_TIME_BITS-1:0] open_limit   = wbdc_pkg::RST_OPEN_TIME;
   logic [wbdc_pkg::CFG_TIME_BITS-1:0] close_limit  = wbdc_pkg::RST_CLOSE_TIME;
   logic [wbdc_pkg::CFG_TIME_BITS-1:0] empty_limit  = wbdc_pkg::RST_EMPTYING_TIME;
   logic [wbdc_pkg::LEVEL_BITS-1:0]    empty_mark   = wbdc_pkg::RST_EMPTY_LEVEL;
   logic [wbdc_pkg::LEVEL_BITS-1:0]    full_mark    = wbdc_pkg::RST_FULL_LEVEL;

   tick_word_type   tick_q[$];
   status_word_type expected_status_q[$];
   tick_word_type   offered_tick;

   int tx_idle_pct   = 36;
   int rx_idle_pct   = 63;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int mismatches    = 0;
   int results_seen  = 0;
   int cycle_count   = 0;

   waste_bin_door_controller_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_user_present   (req_user_present),
      .req_open_button    (req_open_button),
      .req_close_button   (req_close_button),
      .req_fill_distance  (req_fill_distance),
      .req_empty_request  (req_empty_request),
      .req_problem_active (req_problem_active),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mode_now       (rsp_mode_now),
      .rsp_door_command   (rsp_door_command),
      .rsp_message_code   (rsp_message_code),
      .rsp_green_led      (rsp_green_led),
      .rsp_red_led        (rsp_red_led),
      .rsp_percent_valid  (rsp_percent_valid),
      .rsp_fill_percent   (rsp_fill_percent),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [wbdc_pkg::PCT_BITS-1:0] fill_pct(
      logic [wbdc_pkg::LEVEL_BITS-1:0] d);
      int unsigned q;
      if (d >= empty_mark) return '0;
      if (d <= full_mark) return wbdc_pkg::PCT_BITS'(wbdc_pkg::PCT_FULL);
      q = (wbdc_pkg::PCT_FULL * (empty_mark - d)) / (empty_mark - full_mark);
      return (q > wbdc_pkg::PCT_FULL) ? wbdc_pkg::PCT_BITS'(wbdc_pkg::PCT_FULL)
                                      : wbdc_pkg::PCT_BITS'(q);
   endfunction

   function automatic void switch_mode(wbdc_pkg::mode_type m);
      cur_mode  = m;
      entry_due = 1'b1;
   endfunction

   // one tick of the controller; updates the predicted state
   function automatic status_word_type advance_controller(tick_word_type t);
      status_word_type  s;
      longint unsigned  sum;
      s = '0;
      if (t.problem) begin
         problem_seen = 1'b1;
      end else begin
         // leaving a problem replays the entry action of the current mode
         if (problem_seen) entry_due = 1'b1;
         problem_seen = 1'b0;
         if ((cur_mode == wbdc_pkg::MODE_OPEN || cur_mode == wbdc_pkg::MODE_CLOSE ||
              cur_mode == wbdc_pkg::MODE_EMPTYING) && !entry_due) begin
            sum = longint'(dwell_ms) + t.elapsed;
            if (sum > longint'({wbdc_pkg::TIMER_BITS{1'b1}})) dwell_ms = '1;
            else dwell_ms = wbdc_pkg::TIMER_BITS'(sum);
         end
         case (cur_mode)
            wbdc_pkg::MODE_OPEN: begin
               s.pct_valid = 1'b1;
               s.pct = fill_pct(t.fill_dist);
               if (entry_due) begin
                  s.msg = wbdc_pkg::MSG_OPENED;
                  s.door = wbdc_pkg::DOOR_OPEN;
                  dwell_ms = '0;
                  entry_due = 1'b0;
               end
               if (dwell_ms > open_limit || t.close_btn) switch_mode(wbdc_pkg::MODE_CLOSE);
               // full wins over close
               if (t.fill_dist <= full_mark && dwell_ms > wbdc_pkg::OPEN_FULL_MIN_MS)
                  switch_mode(wbdc_pkg::MODE_FULL);
            end
            wbdc_pkg::MODE_SLEEP: begin
               if (entry_due) begin
                  s.msg = wbdc_pkg::MSG_BLANK;
                  entry_due = 1'b0;
               end
               if (t.user) switch_mode(wbdc_pkg::MODE_IDLE);
            end
            wbdc_pkg::MODE_CLOSE: begin
               if (entry_due) begin
                  s.msg = wbdc_pkg::MSG_RECEIVED;
                  s.door = wbdc_pkg::DOOR_CLOSE;
                  dwell_ms = '0;
                  entry_due = 1'b0;
               end
               if (dwell_ms > close_limit) switch_mode(wbdc_pkg::MODE_IDLE);
            end
            wbdc_pkg::MODE_EMPTYING: begin
               s.pct_valid = 1'b1;
               s.pct = fill_pct(t.fill_dist);
               if (entry_due) begin
                  s.msg = wbdc_pkg::MSG_EMPTYING;
                  s.door = wbdc_pkg::DOOR_REVERSE;
                  dwell_ms = '0;
                  entry_due = 1'b0;
               end
               if (dwell_ms > empty_limit) begin
                  s.door = wbdc_pkg::DOOR_CLOSE;
                  switch_mode(wbdc_pkg::MODE_IDLE);
               end
            end
            wbdc_pkg::MODE_FULL: begin
               if (entry_due) begin
                  s.msg = wbdc_pkg::MSG_FULL;
                  s.door = wbdc_pkg::DOOR_CLOSE;
                  green_on = 1'b0;
                  red_on = 1'b1;
                  entry_due = 1'b0;
               end
               if (t.empty_req) switch_mode(wbdc_pkg::MODE_EMPTYING);
            end
            default: begin
               cur_mode = wbdc_pkg::MODE_IDLE;
               if (t.user) begin
                  if (entry_due) begin
                     green_on = 1'b1;
                     red_on = 1'b0;
                     s.msg = wbdc_pkg::MSG_PRESS_OPEN;
                     entry_due = 1'b0;
                  end
                  if (t.open_btn) switch_mode(wbdc_pkg::MODE_OPEN);
               end else begin
                  // idle entry stays pending for the return from sleep
                  switch_mode(wbdc_pkg::MODE_SLEEP);
               end
            end
         endcase
      end
      s.mode  = cur_mode;
      s.green = green_on;
      s.red   = red_on;
      return s;
   endfunction

   task automatic report_mismatch(string what);
      $display("MISMATCH word %0d at %0t: %s", results_seen, $time, what);
      mismatches++;
   endtask

   task automatic push_tick(int el, bit u, bit ob, bit cb, int d, bit er, bit pr);
      tick_word_type t;
      t.elapsed   = wbdc_pkg::ELAPSED_BITS'(el);
      t.user      = u;
      t.open_btn  = ob;
      t.close_btn = cb;
      t.fill_dist = wbdc_pkg::LEVEL_BITS'(d);
      t.empty_req = er;
      t.problem   = pr;
      tick_q.push_back(t);
   endtask

   // mostly progressing traffic: users present, fill near the thresholds
   function automatic tick_word_type random_tick();
      tick_word_type t;
      int            pick;
      pick = $urandom_range(9, 0);
      t.elapsed   = ($urandom_range(1, 0) != 0)
                    ? wbdc_pkg::ELAPSED_BITS'($urandom_range(255, 150))
                    : wbdc_pkg::ELAPSED_BITS'($urandom_range(255, 0));
      t.user      = $urandom_range(99, 0) < 85;
      t.open_btn  = $urandom_range(99, 0) < 40;
      t.close_btn = $urandom_range(99, 0) < 8;
      t.empty_req = $urandom_range(99, 0) < 30;
      t.problem   = $urandom_range(99, 0) < 4;
      if (pick < 4)
         t.fill_dist = wbdc_pkg::LEVEL_BITS'($urandom_range(full_mark, 0));
      else if (pick < 7)
         t.fill_dist = wbdc_pkg::LEVEL_BITS'($urandom_range(empty_mark, full_mark));
      else
         t.fill_dist = wbdc_pkg::LEVEL_BITS'($urandom_range(1023, 0));
      return t;
   endfunction

   task automatic write_reg(logic [wbdc_pkg::CSR_IDX_BITS-1:0] idx,
                            logic [wbdc_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         wbdc_pkg::CSR_OPEN_TIME:     open_limit  = val;
         wbdc_pkg::CSR_CLOSE_TIME:    close_limit = val;
         wbdc_pkg::CSR_EMPTYING_TIME: empty_limit = val;
         wbdc_pkg::CSR_EMPTY_LEVEL:   empty_mark  = val[wbdc_pkg::LEVEL_BITS-1:0];
         wbdc_pkg::CSR_FULL_LEVEL:    full_mark   = val[wbdc_pkg::LEVEL_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(int open_ms, int close_ms, int empty_ms, int em, int fm);
      write_reg(wbdc_pkg::CSR_OPEN_TIME, wbdc_pkg::CSR_DATA_BITS'(open_ms));
      write_reg(wbdc_pkg::CSR_CLOSE_TIME, wbdc_pkg::CSR_DATA_BITS'(close_ms));
      write_reg(wbdc_pkg::CSR_EMPTYING_TIME, wbdc_pkg::CSR_DATA_BITS'(empty_ms));
      write_reg(wbdc_pkg::CSR_EMPTY_LEVEL, wbdc_pkg::CSR_DATA_BITS'(em));
      write_reg(wbdc_pkg::CSR_FULL_LEVEL, wbdc_pkg::CSR_DATA_BITS'(fm));
   endtask

   task automatic wait_drained();
      while (tick_q.size() != 0 || req_valid || expected_status_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // driver: predict on acceptance, then offer the next word or a gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_status_q.push_back(advance_controller(offered_tick));
         if (!req_valid || !req_stall) begin
            if (tick_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
               offered_tick = tick_q.pop_front();
               req_elapsed_ms     <= offered_tick.elapsed;
               req_user_present   <= offered_tick.user;
               req_open_button    <= offered_tick.open_btn;
               req_close_button   <= offered_tick.close_btn;
               req_fill_distance  <= offered_tick.fill_dist;
               req_empty_request  <= offered_tick.empty_req;
               req_problem_active <= offered_tick.problem;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long output hold-off, started from the stimulus block
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (hold_left != 0) || ($urandom_range(99, 0) < rx_idle_pct);
   end

   always @(posedge clock) begin : monitor
      status_word_type got;
      status_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_mode_now, rsp_door_command, rsp_message_code, rsp_green_led,
                rsp_red_led, rsp_percent_valid, rsp_fill_percent};
         if (expected_status_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word, mode_now %0d", got.mode));
         end else begin
            want = expected_status_q.pop_front();
            if (got.mode !== want.mode)
               report_mismatch($sformatf("mode_now %0d, want %0d", got.mode, want.mode));
            if (got.door !== want.door)
               report_mismatch($sformatf("door_command %0d, want %0d", got.door, want.door));
            if (got.msg !== want.msg)
               report_mismatch($sformatf("message_code %0d, want %0d", got.msg, want.msg));
            if (got.green !== want.green)
               report_mismatch($sformatf("green_led %0d, want %0d", got.green, want.green));
            if (got.red !== want.red)
               report_mismatch($sformatf("red_led %0d, want %0d", got.red, want.red));
            if (got.pct_valid !== want.pct_valid)
               report_mismatch($sformatf("percent_valid %0d, want %0d",
                                         got.pct_valid, want.pct_valid));
            if (got.pct !== want.pct)
               report_mismatch($sformatf("fill_percent %0d, want %0d", got.pct, want.pct));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed walk at reset settings
      push_tick(0,   0, 0, 0, 500,  0, 0);   // idle, no user: to sleep
      push_tick(255, 0, 1, 1, 500,  1, 0);   // sleep entry
      push_tick(10,  1, 0, 0, 500,  0, 0);   // user back: idle
      push_tick(10,  1, 0, 0, 500,  0, 0);   // idle entry, green on
      push_tick(10,  1, 1, 0, 500,  0, 0);   // open button
      push_tick(255, 1, 0, 0, 1023, 0, 0);   // open entry, empty bin
      push_tick(255, 1, 0, 0, 0,    0, 1);   // problem holds everything
      push_tick(0,   1, 0, 0, 0,    0, 0);   // problem gone: open entry again
      repeat (4) push_tick(255, 1, 0, 0, 110, 0, 0);
      push_tick(255, 1, 0, 1, 20,   0, 0);   // full beats close button
      push_tick(0,   0, 0, 0, 20,   0, 0);   // full entry, red on
      push_tick(0,   0, 0, 0, 20,   1, 1);   // empty command masked by problem
      push_tick(0,   0, 0, 0, 20,   1, 0);   // full entry again, to emptying
      push_tick(255, 0, 0, 0, 200,  0, 0);   // emptying entry, at empty level
      push_tick(255, 0, 0, 0, 21,   0, 0);   // just above full level
      push_tick(255, 1, 1, 0, 19,   0, 0);
      repeat (150) tick_q.push_back(random_tick());
      wait_drained();

      configure(2500, 200, 300, 900, 100);
      repeat (250) tick_q.push_back(random_tick());
      wait_drained();

      tx_idle_pct <= 63;
      rx_idle_pct <= 36;
      configure(65535, 0, 0, 1023, 0);
      // get into open, then stay until the timer saturates
      repeat (10) push_tick(255, 1, 1, 0, 500, 1, 0);
      repeat (270) push_tick(255, 1, 0, 0, 500, 0, 0);
      repeat (80) tick_q.push_back(random_tick());
      wait_drained();

      configure(0, 1, 65535, 0, 1023);
      repeat (120) tick_q.push_back(random_tick());
      wait_drained();

      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      configure(1500, 600, 900, 700, 150);
      hold_requests <= hold_requests + 1;
      repeat (150) tick_q.push_back(random_tick());
      wait_drained();

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/wbdc_pkg.sv
src/wbdc_ctrl.sv
src/wbdc_dpath.sv
src/waste_bin_door_controller_core.sv
verif/testbench.sv
